// File: design/assert_macros.svh
// Assertion macros shared by the checker files of the deframer.
// Depends on nothing; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");

`endif

// File: design/scfd_pkg.sv
// Shared types and constants of the sync/length/checksum deframer.
// Depends on nothing; used by scfd_step, the top level and the checker.
package scfd_pkg;

	// Framing bytes.
	localparam logic [7:0] SYNC_FIRST   = 8'hA5;
	localparam logic [7:0] SYNC_SECOND  = 8'h5A;
	localparam logic [7:0] TRAILER_BYTE = 8'hAA;

	// Phase codes of the frame parser.
	localparam logic [2:0] PH_HUNT1   = 3'd0;
	localparam logic [2:0] PH_HUNT2   = 3'd1;
	localparam logic [2:0] PH_LEN     = 3'd2;
	localparam logic [2:0] PH_BODY    = 3'd3;
	localparam logic [2:0] PH_CHECK   = 3'd4;
	localparam logic [2:0] PH_TRAILER = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_BODY      = 2'd0;
	localparam logic [1:0] KIND_OK        = 2'd1;
	localparam logic [1:0] KIND_BAD_SUM   = 2'd2;
	localparam logic [1:0] KIND_BAD_TRAIL = 2'd3;

	// Parser state carried from one item to the next.
	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] frame_length;
		logic [7:0] body_count;
		logic [7:0] running_sum;
		logic       sum_matched;
	} state_t;

	// One result item plus a flag that says whether the input item made one.
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] body_byte;
		logic [7:0] position;
	} result_t;

endpackage

// File: design/sum_checked_frame_deframer_core.sv
// Top level of the sync/length/checksum deframer: state and result registers.
// Depends on scfd_pkg and instantiates scfd_step.
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_ready, byte_in        | sink
//   out     | out_valid, out_ready, kind,        | source
//           | body_byte, position                |
//
// One byte is taken per cycle; its result, if any, shows on the output
// register in the next cycle, set by the single state update per byte.
// A new byte is taken while the output register is empty or being emptied.
// When the output stalls with a result waiting, input stalls too.
// Reset returns the parser to hunting for the first sync byte.
module sum_checked_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] body_byte,
	output logic [7:0] position
);

	scfd_pkg::state_t  state_q;
	scfd_pkg::state_t  state_nxt;
	scfd_pkg::result_t res;
	logic              in_acc;
	logic [1:0]        kind_q;
	logic [7:0]        body_byte_q;
	logic [7:0]        position_q;
	logic              out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	scfd_step u_step (
		.cur     (state_q),
		.byte_in (byte_in),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Parser state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: scfd_pkg::PH_HUNT1, frame_length: 8'd0,
				body_count: 8'd0, running_sum: 8'd0, sum_matched: 1'b0};
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// Output valid flag: set by an item with a result, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (in_acc && res.valid) begin
			kind_q      <= res.kind;
			body_byte_q <= res.body_byte;
			position_q  <= res.position;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign body_byte = body_byte_q;
	assign position  = position_q;

endmodule

// File: design/scfd_step.sv
// Next-state and result logic of the deframer for one received byte.
// Depends on scfd_pkg for the state and result types and the codes.
module scfd_step (
	input  scfd_pkg::state_t  cur,
	input  logic [7:0]        byte_in,
	output scfd_pkg::state_t  nxt,
	output scfd_pkg::result_t res
);

	logic [7:0] count_inc;
	logic [7:0] sum_add;

	assign count_inc = cur.body_count + 8'd1;
	assign sum_add   = cur.running_sum + byte_in;

	// One parser step: update the state and form at most one result item.
	always_comb begin
		nxt           = cur;
		res.valid     = 1'b0;
		res.kind      = scfd_pkg::KIND_BODY;
		res.body_byte = 8'd0;
		res.position  = 8'd0;
		unique case (cur.phase)
			scfd_pkg::PH_HUNT2: begin
				// A repeated first sync byte keeps waiting for the second.
				if (byte_in == scfd_pkg::SYNC_SECOND) begin
					nxt.phase = scfd_pkg::PH_LEN;
				end else if (byte_in != scfd_pkg::SYNC_FIRST) begin
					nxt.phase = scfd_pkg::PH_HUNT1;
				end
			end
			scfd_pkg::PH_LEN: begin
				nxt.frame_length = byte_in;
				nxt.running_sum  = byte_in;
				nxt.body_count   = 8'd0;
				nxt.sum_matched  = 1'b0;
				// An empty body goes straight to the checksum byte.
				nxt.phase = (byte_in == 8'd0) ? scfd_pkg::PH_CHECK : scfd_pkg::PH_BODY;
			end
			scfd_pkg::PH_BODY: begin
				res.valid       = 1'b1;
				res.kind        = scfd_pkg::KIND_BODY;
				res.body_byte   = byte_in;
				res.position    = cur.body_count;
				nxt.running_sum = sum_add;
				nxt.body_count  = count_inc;
				if (count_inc == cur.frame_length) begin
					nxt.phase = scfd_pkg::PH_CHECK;
				end
			end
			scfd_pkg::PH_CHECK: begin
				nxt.sum_matched = (byte_in == cur.running_sum);
				nxt.phase       = scfd_pkg::PH_TRAILER;
			end
			scfd_pkg::PH_TRAILER: begin
				// A bad checksum wins over a bad trailer.
				res.valid    = 1'b1;
				res.position = cur.frame_length;
				if (!cur.sum_matched) begin
					res.kind = scfd_pkg::KIND_BAD_SUM;
				end else if (byte_in != scfd_pkg::TRAILER_BYTE) begin
					res.kind = scfd_pkg::KIND_BAD_TRAIL;
				end else begin
					res.kind = scfd_pkg::KIND_OK;
				end
				nxt.phase = scfd_pkg::PH_HUNT1;
			end
			default: begin
				// Hunting for the first sync byte; unused codes act the same.
				nxt.phase = (byte_in == scfd_pkg::SYNC_FIRST) ?
					scfd_pkg::PH_HUNT2 : scfd_pkg::PH_HUNT1;
			end
		endcase
	end

endmodule

// File: design/scfd_checker.sv
// Port-level checks of the deframer, bound to the top level.
// Depends on scfd_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module scfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] body_byte,
	input logic [7:0] position
);

	// No result item is offered while reset is held.
	`ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !out_valid)

	// Input only stalls behind a waiting result that is not being taken.
	`ASSERT_CLKD(a_stall_cause, clk, arst_n, !in_ready |-> (out_valid && !out_ready))

	// Verdict items carry a zero byte value.
	`ASSERT_CLKD(a_verdict_zero, clk, arst_n, (out_valid && kind != scfd_pkg::KIND_BODY) |-> body_byte == 8'd0)

	// A stalled result item holds still.
	`ASSERT_CLKD(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(body_byte) && $stable(position)))

endmodule

bind sum_checked_frame_deframer_core scfd_checker u_scfd_checker (.*);
